/* sv/bdds_pkg.sv */
// shared types and constants for the delay-difference biomass step
`default_nettype none
package bdds_pkg;

    // register map indexes
    typedef enum logic [2:0] {
        REG_QT   = 3'd0,
        REG_QN   = 3'd1,
        REG_M    = 3'd2,
        REG_RHO  = 3'd3,
        REG_WK   = 3'd4,
        REG_WK1  = 3'd5,
        REG_B0   = 3'd6,
        REG_B1   = 3'd7
    } reg_idx_t;

    // configuration register set
    typedef struct packed {
        logic [23:0] qt;
        logic [23:0] qn;
        logic [23:0] m;
        logic [15:0] rho;
        logic [15:0] wk;
        logic [15:0] wk1;
        logic [31:0] b0;
        logic [31:0] b1;
    } cfg_t;

    // run phase of the recurrence
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LATER  = 2'd2
    } phase_t;

    // controller states, one per datapath operation
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MQT,
        ST_MQN,
        ST_MRS,
        ST_LKP,
        ST_MRC,
        ST_MRD,
        ST_MB1,
        ST_MWR,
        ST_MCB,
        ST_MDR,
        ST_SUB,
        ST_DONE
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL_QT,
        OP_MUL_QN,
        OP_MUL_RHO,
        OP_LOOKUP,
        OP_MUL_RC,
        OP_MUL_RD,
        OP_MUL_B1,
        OP_MUL_WK,
        OP_MUL_B2,
        OP_MUL_R1,
        OP_SUB,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* sv/bdds_cfg.sv */
// apb configuration registers
`default_nettype none
module bdds_cfg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output bdds_pkg::cfg_t         cfg
);
    bdds_pkg::cfg_t   cfg_reg;
    bdds_pkg::cfg_t   cfg_next;
    bdds_pkg::reg_idx_t idx;

    assign idx    = bdds_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write
    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                bdds_pkg::REG_QT:  cfg_next.qt  = pwdata[23:0];
                bdds_pkg::REG_QN:  cfg_next.qn  = pwdata[23:0];
                bdds_pkg::REG_M:   cfg_next.m   = pwdata[23:0];
                bdds_pkg::REG_RHO: cfg_next.rho = pwdata[15:0];
                bdds_pkg::REG_WK:  cfg_next.wk  = pwdata[15:0];
                bdds_pkg::REG_WK1: cfg_next.wk1 = pwdata[15:0];
                bdds_pkg::REG_B0:  cfg_next.b0  = pwdata;
                bdds_pkg::REG_B1:  cfg_next.b1  = pwdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register read
    always_comb begin
        case (idx)
            bdds_pkg::REG_QT:  prdata = {8'd0, cfg_reg.qt};
            bdds_pkg::REG_QN:  prdata = {8'd0, cfg_reg.qn};
            bdds_pkg::REG_M:   prdata = {8'd0, cfg_reg.m};
            bdds_pkg::REG_RHO: prdata = {16'd0, cfg_reg.rho};
            bdds_pkg::REG_WK:  prdata = {16'd0, cfg_reg.wk};
            bdds_pkg::REG_WK1: prdata = {16'd0, cfg_reg.wk1};
            bdds_pkg::REG_B0:  prdata = cfg_reg.b0;
            bdds_pkg::REG_B1:  prdata = cfg_reg.b1;
            default:           prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

/* sv/bdds_ctrl.sv */
// controller state machine sequencing the shared multiplier
`default_nettype none
module bdds_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  bdds_pkg::status_t      status,
    output bdds_pkg::cmd_t         cmd,
    output logic                   s_tready
);
    bdds_pkg::state_t state_reg;
    bdds_pkg::state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bdds_pkg::ST_IDLE: if (s_tvalid) state_next = bdds_pkg::ST_MQT;
            bdds_pkg::ST_MQT:  state_next = bdds_pkg::ST_MQN;
            bdds_pkg::ST_MQN:  state_next = bdds_pkg::ST_MRS;
            bdds_pkg::ST_MRS:  state_next = bdds_pkg::ST_LKP;
            bdds_pkg::ST_LKP:  state_next = bdds_pkg::ST_MRC;
            bdds_pkg::ST_MRC:  state_next = bdds_pkg::ST_MRD;
            bdds_pkg::ST_MRD:  state_next = bdds_pkg::ST_MB1;
            bdds_pkg::ST_MB1:  state_next = bdds_pkg::ST_MWR;
            bdds_pkg::ST_MWR:  state_next = bdds_pkg::ST_MCB;
            bdds_pkg::ST_MCB:  state_next = bdds_pkg::ST_MDR;
            bdds_pkg::ST_MDR:  state_next = bdds_pkg::ST_SUB;
            bdds_pkg::ST_SUB:  state_next = bdds_pkg::ST_DONE;
            bdds_pkg::ST_DONE: if (status.out_free) state_next = bdds_pkg::ST_IDLE;
            default:           state_next = bdds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdds_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command outputs
    always_comb begin
        s_tready = 1'b0;
        case (state_reg)
            bdds_pkg::ST_IDLE: begin
                cmd.op   = bdds_pkg::OP_IDLE;
                s_tready = 1'b1;
            end
            bdds_pkg::ST_MQT:  cmd.op = bdds_pkg::OP_MUL_QT;
            bdds_pkg::ST_MQN:  cmd.op = bdds_pkg::OP_MUL_QN;
            bdds_pkg::ST_MRS:  cmd.op = bdds_pkg::OP_MUL_RHO;
            bdds_pkg::ST_LKP:  cmd.op = bdds_pkg::OP_LOOKUP;
            bdds_pkg::ST_MRC:  cmd.op = bdds_pkg::OP_MUL_RC;
            bdds_pkg::ST_MRD:  cmd.op = bdds_pkg::OP_MUL_RD;
            bdds_pkg::ST_MB1:  cmd.op = bdds_pkg::OP_MUL_B1;
            bdds_pkg::ST_MWR:  cmd.op = bdds_pkg::OP_MUL_WK;
            bdds_pkg::ST_MCB:  cmd.op = bdds_pkg::OP_MUL_B2;
            bdds_pkg::ST_MDR:  cmd.op = bdds_pkg::OP_MUL_R1;
            bdds_pkg::ST_SUB:  cmd.op = bdds_pkg::OP_SUB;
            bdds_pkg::ST_DONE: cmd.op = bdds_pkg::OP_COMMIT;
            default:           cmd.op = bdds_pkg::OP_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/bdds_dp.sv */
// datapath: shared multiplier, accumulator, exponential table and step state
`default_nettype none
module bdds_dp #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  bdds_pkg::cfg_t         cfg,
    input  bdds_pkg::cmd_t         cmd,
    output bdds_pkg::status_t      status,
    input  wire logic              in_load,
    input  wire logic              in_start,
    input  wire logic [15:0]       in_et,
    input  wire logic [15:0]       in_en,
    input  wire logic [31:0]       in_rec,
    output logic      [31:0]       out_biomass,
    output logic                   out_low,
    output logic                   out_high,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    localparam int LG = $clog2(EXP_TABLE_DEPTH);

    // exp(-16*i/depth) in Q2.14
    function automatic logic [EXP_TABLE_DEPTH*16-1:0] build_rom();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] base;
        logic [63:0] cur;
        logic [EXP_TABLE_DEPTH*16-1:0] rom;
        term = 64'd1 << 58;
        sum  = term;
        for (int n = 1; n <= 40; n++) begin
            term = ((term << 4) >> LG) / 64'(n);
            if (n[0]) sum = sum - term;
            else      sum = sum + term;
        end
        base = (sum + (64'd1 << 27)) >> 28;
        cur  = 64'd1 << 30;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            rom[i*16 +: 16] = 16'((cur + (64'd1 << 15)) >> 16);
            cur = (cur * base + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam logic [EXP_TABLE_DEPTH*16-1:0] EXP_ROM = build_rom();

    // latched item
    logic              start_reg;
    logic [15:0]       et_reg;
    logic [15:0]       en_reg;
    logic [31:0]       rec_reg;

    // working registers
    logic [51:0]        prod_reg;
    logic [51:0]        prod_next;
    logic signed [53:0] acc_reg;
    logic signed [53:0] acc_next;
    logic [17:0]        r_reg;
    logic [19:0]        c_reg;
    logic [19:0]        d_reg;
    logic [15:0]        snew_reg;

    // recurrence state
    logic [15:0]       s1_reg;
    logic [15:0]       s2_reg;
    logic [31:0]       b1_reg;
    logic [31:0]       b2_reg;
    logic [31:0]       r1_reg;
    bdds_pkg::phase_t  phase_reg;

    // output register
    logic              ovalid_reg;
    logic [31:0]       obio_reg;
    logic              olow_reg;
    logic              ohigh_reg;

    logic [31:0]       mul_a;
    logic [19:0]       mul_b;
    logic [51:0]       rnd_prod;
    logic [LG-1:0]     tbl_idx;
    logic              x_over;
    logic [39:0]       acc_rnd;
    logic              commit;
    bdds_pkg::phase_t  phase_eff;
    logic [31:0]       res_b;
    logic              res_low;
    logic              res_high;

    assign status.out_free = !ovalid_reg || out_ready;
    assign commit          = (cmd.op == bdds_pkg::OP_COMMIT) && status.out_free;

    // multiplier operand select
    always_comb begin
        case (cmd.op)
            bdds_pkg::OP_MUL_QT:  begin mul_a = {8'd0, cfg.qt};  mul_b = {4'd0, et_reg};    end
            bdds_pkg::OP_MUL_QN:  begin mul_a = {8'd0, cfg.qn};  mul_b = {4'd0, en_reg};    end
            bdds_pkg::OP_MUL_RHO: begin mul_a = {16'd0, cfg.rho}; mul_b = {4'd0, s1_reg};   end
            bdds_pkg::OP_MUL_RC:  begin mul_a = {14'd0, r_reg};  mul_b = {4'd0, s2_reg};    end
            bdds_pkg::OP_MUL_RD:  begin mul_a = {14'd0, r_reg};  mul_b = {4'd0, cfg.wk1};   end
            bdds_pkg::OP_MUL_B1:  begin
                mul_a = b1_reg;
                mul_b = 20'({4'd0, s1_reg} + {2'd0, r_reg});
            end
            bdds_pkg::OP_MUL_WK:  begin mul_a = rec_reg; mul_b = {4'd0, cfg.wk}; end
            bdds_pkg::OP_MUL_B2:  begin mul_a = b2_reg;  mul_b = c_reg;          end
            bdds_pkg::OP_MUL_R1:  begin mul_a = r1_reg;  mul_b = d_reg;          end
            default:              begin mul_a = '0;      mul_b = '0;             end
        endcase
    end

    assign prod_next = 52'(mul_a) * 52'(mul_b);
    assign rnd_prod  = (prod_reg + 52'd8192) >> 14;

    // table index from the total mortality rate
    assign tbl_idx = acc_reg[27 -: LG];
    assign x_over  = |acc_reg[53:28];

    // accumulator
    always_comb begin
        case (cmd.op)
            bdds_pkg::OP_MUL_QN:  acc_next = $signed({30'd0, cfg.m}) + $signed({2'd0, prod_reg});
            bdds_pkg::OP_MUL_RHO: acc_next = acc_reg + $signed({2'd0, prod_reg});
            bdds_pkg::OP_MUL_WK:  acc_next = $signed({2'd0, prod_reg});
            bdds_pkg::OP_MUL_B2:  acc_next = acc_reg + $signed({2'd0, prod_reg});
            bdds_pkg::OP_MUL_R1:  acc_next = acc_reg - $signed({2'd0, prod_reg});
            bdds_pkg::OP_SUB:     acc_next = acc_reg - $signed({2'd0, prod_reg});
            default:              acc_next = acc_reg;
        endcase
    end

    // final rounding, clamp and saturation, or the configured initial biomass in the first two phases
    assign acc_rnd   = 40'((acc_reg + 54'sd8192) >>> 14);
    assign phase_eff = start_reg ? bdds_pkg::PH_FIRST : phase_reg;
    always_comb begin
        res_low  = 1'b0;
        res_high = 1'b0;
        case (phase_eff)
            bdds_pkg::PH_FIRST:  res_b = cfg.b0;
            bdds_pkg::PH_SECOND: res_b = cfg.b1;
            default: begin
                if (acc_reg[53]) begin
                    res_b   = 32'd0;
                    res_low = 1'b1;
                end else if (|acc_rnd[39:32]) begin
                    res_b    = 32'hFFFF_FFFF;
                    res_high = 1'b1;
                end else begin
                    res_b = acc_rnd[31:0];
                end
            end
        endcase
    end

    // payload, working and output data registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            start_reg <= in_start;
            et_reg    <= in_et;
            en_reg    <= in_en;
            rec_reg   <= in_rec;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.op == bdds_pkg::OP_LOOKUP) begin
            snew_reg <= x_over ? 16'd0 : EXP_ROM[{tbl_idx, 4'd0} +: 16];
            r_reg    <= rnd_prod[17:0];
        end
        if (cmd.op == bdds_pkg::OP_MUL_RD) c_reg <= rnd_prod[19:0];
        if (cmd.op == bdds_pkg::OP_MUL_B1) d_reg <= rnd_prod[19:0];
        if (commit) begin
            obio_reg  <= res_b;
            olow_reg  <= res_low;
            ohigh_reg <= res_high;
        end
    end

    // recurrence state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg     <= '0;
            s2_reg     <= '0;
            b1_reg     <= '0;
            b2_reg     <= '0;
            r1_reg     <= '0;
            phase_reg  <= bdds_pkg::PH_FIRST;
            ovalid_reg <= 1'b0;
        end else begin
            if (commit) begin
                s2_reg <= s1_reg;
                s1_reg <= snew_reg;
                b2_reg <= b1_reg;
                b1_reg <= res_b;
                r1_reg <= rec_reg;
                case (phase_eff)
                    bdds_pkg::PH_FIRST:  phase_reg <= bdds_pkg::PH_SECOND;
                    default:             phase_reg <= bdds_pkg::PH_LATER;
                endcase
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_biomass = obio_reg;
    assign out_low     = olow_reg;
    assign out_high    = ohigh_reg;
endmodule
`default_nettype wire

/* sv/biomass_delay_difference_step.sv */
// Delay-difference biomass step, one model time step per input request.
// Input stream: s_tdata carries targeted effort, non-targeted effort and the
// step's recruitment (Q24.8); s_tuser flags the first step of a new run.
// Output stream: m_tdata is the step's biomass (Q24.8), m_tuser holds the
// clamped-to-zero and saturated flags. Parameters are written over APB.
// A request is taken only while the controller is idle, so the next one waits
// until this one is committed; one shared 32x20 multiplier does the nine
// products of a step in sequence, plus one table lookup.
// Steps 0 and 1 of a run return the configured initial biomasses; later
// steps apply the second-order recurrence with rounding, clamp and saturate.
// Reset clears config registers, recurrence state and the run phase; the first
// request after reset is treated as step 0. The exponential table is constant.
// A finished result sits in an output register; if the receiver stalls, the
// next request is accepted and computed, then held before its commit until
// the previous result has been taken.
`default_nettype none
module biomass_delay_difference_step #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // [15:0] targeted_effort, [31:16] nontargeted_effort, [63:32] recruitment
    input  wire logic [63:0] s_tdata,
    // [0] run_start
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] biomass
    output logic      [31:0] m_tdata,
    // [0] clamped_low, [1] saturated_high
    output logic      [1:0]  m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    bdds_pkg::cfg_t    cfg;
    bdds_pkg::cmd_t    cmd;
    bdds_pkg::status_t status;
    logic              low;
    logic              high;

    bdds_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    bdds_dp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .in_load     (s_tvalid && s_tready),
        .in_start    (s_tuser),
        .in_et       (s_tdata[15:0]),
        .in_en       (s_tdata[31:16]),
        .in_rec      (s_tdata[63:32]),
        .out_biomass (m_tdata),
        .out_low     (low),
        .out_high    (high),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tuser = {high, low};
endmodule
`default_nettype wire

/* sv/bdds_check.sv */
// port-level checker for the biomass step, bound to the top level
`default_nettype none
module bdds_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    // a stalled result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second request taken");

    // clamp and saturation never together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("both flags set");

    // a clamped result is zero
    a_clamp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0) else $error("clamp not zero");
endmodule

bind biomass_delay_difference_step bdds_check u_bdds_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

/* test/biomass_delay_difference_step_test.sv */
// testbench for the delay-difference biomass step: table-driven and random steps checked
`default_nettype none
module biomass_delay_difference_step_test;

    localparam int TABLE_DEPTH = 256;
    localparam int RANDOM_PHASES = 6;
    localparam int STEPS_PER_PHASE = 272;

    logic        aclk;
    logic        aresetn;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    biomass_delay_difference_step DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // one biomass result
    typedef struct packed {
        logic [31:0] biomass;
        logic        clamped;
        logic        saturated;
    } biomass_t;

    // one directed step, with an optional typed-in result
    typedef struct {
        int          group;
        logic        run_start;
        logic [15:0] et;
        logic [15:0] en;
        logic [31:0] rec;
        bit          typed;
        biomass_t    result;
    } step_row_t;

    // override of the predicted result for one request
    typedef struct packed {
        bit       typed;
        biomass_t result;
    } override_t;

    biomass_t  expected_biomass_q[$];
    override_t override_q[$];
    int        fail_count;
    bit        quiet;

    // predictor copy of registers and recurrence state
    bdds_pkg::cfg_t   cfg;
    logic [15:0]      exp_lut [TABLE_DEPTH];
    logic [15:0]      surv1, surv2;
    logic [31:0]      bio1, bio2, rec1;
    bdds_pkg::phase_t run_phase;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // exponential table, same integer recipe as the block
    function automatic void build_exp_lut();
        logic [63:0] term, sum, base, cur;
        term = 64'd1 << 58;
        sum = term;
        for (int n = 1; n <= 40; n++) begin
            term = (term * 64'd16) / (64'(TABLE_DEPTH) * 64'(n));
            if (n % 2) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        base = (sum + (64'd1 << 27)) >> 28;
        cur = 64'd1 << 30;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            exp_lut[i] = 16'((cur + (64'd1 << 15)) >> 16);
            cur = (cur * base + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic logic [63:0] round_q14(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd8192) >> 14;
    endfunction

    // advance the recurrence by one step and return its biomass
    function automatic biomass_t step_biomass(logic start, logic [15:0] et, logic [15:0] en,
                                              logic [31:0] rec);
        logic [63:0] x, surv, r, c, d, pos, neg, b;
        biomass_t res;
        x = 64'(cfg.m) + 64'(cfg.qt) * 64'(et) + 64'(cfg.qn) * 64'(en);
        if (x >= (64'd1 << 28)) begin
            surv = 0;
        end else begin
            surv = 64'(exp_lut[(x * TABLE_DEPTH) >> 28]);
        end
        if (start) begin
            run_phase = bdds_pkg::PH_FIRST;
        end
        res = '0;
        case (run_phase)
            bdds_pkg::PH_FIRST: res.biomass = cfg.b0;
            bdds_pkg::PH_SECOND: res.biomass = cfg.b1;
            default: begin
                r = round_q14(64'(cfg.rho), 64'(surv1));
                c = round_q14(r, 64'(surv2));
                d = round_q14(r, 64'(cfg.wk1));
                pos = (64'(surv1) + r) * 64'(bio1) + 64'(cfg.wk) * 64'(rec);
                neg = c * 64'(bio2) + d * 64'(rec1);
                if (neg > pos) begin
                    res.clamped = 1'b1;
                end else begin
                    b = (pos - neg + 64'd8192) >> 14;
                    if (b > 64'hFFFF_FFFF) begin
                        res.biomass = 32'hFFFF_FFFF;
                        res.saturated = 1'b1;
                    end else begin
                        res.biomass = b[31:0];
                    end
                end
            end
        endcase
        surv2 = surv1;
        surv1 = surv[15:0];
        bio2 = bio1;
        bio1 = res.biomass;
        rec1 = rec;
        if (run_phase == bdds_pkg::PH_FIRST) begin
            run_phase = bdds_pkg::PH_SECOND;
        end else begin
            run_phase = bdds_pkg::PH_LATER;
        end
        return res;
    endfunction

    // request and result monitor
    always @(posedge aclk) begin
        biomass_t  pred, got, want;
        override_t ov;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = step_biomass(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]);
                ov = (override_q.size() > 0) ? override_q.pop_front() : '0;
                expected_biomass_q.push_back(ov.typed ? ov.result : pred);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0], m_tuser[1]};
                if (expected_biomass_q.size() == 0) begin
                    $error("result with none expected: biomass %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_biomass_q.pop_front();
                    if (got.biomass !== want.biomass) begin
                        $error("biomass: expected %h actual %h", want.biomass, got.biomass);
                        fail_count++;
                    end
                    if (got.clamped !== want.clamped) begin
                        $error("clamped_low: expected %b actual %b", want.clamped,
                               got.clamped);
                        fail_count++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated_high: expected %b actual %b", want.saturated,
                               got.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stalls: mostly short, a few long, none while quiet
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            if (!quiet) begin
                m_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3))
                    @(negedge aclk);
            end
        end
    end

    function automatic int sender_gap();
        if (quiet) begin
            return 0;
        end
        return ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    task automatic apb_write(bdds_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(bdds_pkg::cfg_t c);
        apb_write(bdds_pkg::REG_QT, 32'(c.qt));
        apb_write(bdds_pkg::REG_QN, 32'(c.qn));
        apb_write(bdds_pkg::REG_M, 32'(c.m));
        apb_write(bdds_pkg::REG_RHO, 32'(c.rho));
        apb_write(bdds_pkg::REG_WK, 32'(c.wk));
        apb_write(bdds_pkg::REG_WK1, 32'(c.wk1));
        apb_write(bdds_pkg::REG_B0, c.b0);
        apb_write(bdds_pkg::REG_B1, c.b1);
        cfg = c;
    endtask

    // wait until every result is back and the block has settled
    task automatic drain();
        while (expected_biomass_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // send one request; valid stays high when no gap follows
    task automatic send_step(logic start, logic [15:0] et, logic [15:0] en, logic [31:0] rec,
                             override_t ov);
        int gap;
        override_q.push_back(ov);
        s_tvalid <= 1'b1;
        s_tuser <= start;
        s_tdata <= {rec, en, et};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    bdds_pkg::cfg_t directed_cfg [3];
    step_row_t steps [] = '{
        // plain run: initial biomasses, then huge effort drives survival to zero
        '{0, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'h0000_6400, 1'b0, 1'b0}},
        '{0, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, '{32'h0000_5000, 1'b0, 1'b0}},
        '{0, 1'b0, 16'h0000, 16'h0000, 32'h0000_0100, 0, '0},
        '{0, 1'b0, 16'h0001, 16'h0001, 32'h0001_0000, 0, '0},
        '{0, 1'b0, 16'h00FF, 16'h0000, 32'h8000_0000, 0, '0},
        '{0, 1'b0, 16'h0000, 16'hFFFF, 32'h0000_0001, 0, '0},
        '{0, 1'b0, 16'h8000, 16'h0000, 32'h0000_0000, 0, '0},
        '{0, 1'b0, 16'h0010, 16'h0100, 32'h0000_3200, 0, '0},
        // new run in the middle of a run
        '{0, 1'b1, 16'h0003, 16'h0007, 32'h0000_0800, 1, '{32'h0000_6400, 1'b0, 1'b0}},
        '{0, 1'b0, 16'h0004, 16'h0002, 32'h0000_0900, 1, '{32'h0000_5000, 1'b0, 1'b0}},
        '{0, 1'b0, 16'h0005, 16'h0001, 32'h0000_0A00, 0, '0},
        '{0, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'h0000_6400, 1'b0, 1'b0}},
        // full survival and maximum growth land exactly on the ceiling
        '{1, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{1, 1'b0, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 0, '0},
        // empty stock after a full one: the loss term clamps to zero
        '{2, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{2, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{2, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{2, 1'b0, 16'h0001, 16'h0000, 32'h0000_0100, 0, '0}
    };

    function automatic bdds_pkg::cfg_t random_cfg(int p);
        bdds_pkg::cfg_t c;
        if (p == 0) begin
            return '1;
        end else if (p == 1) begin
            return '0;
        end
        c.qt = 24'($urandom_range(0, 1 << (8 + $urandom_range(0, 16))));
        c.qn = 24'($urandom_range(0, 1 << (8 + $urandom_range(0, 16))));
        c.m = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12));
        c.rho = 16'($urandom);
        c.wk = 16'($urandom);
        c.wk1 = 16'($urandom);
        c.b0 = $urandom >> $urandom_range(0, 16);
        c.b1 = $urandom >> $urandom_range(0, 16);
        return c;
    endfunction

    // stimulus
    initial begin
        int group;
        logic [15:0] et, en;
        fail_count = 0;
        quiet = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        build_exp_lut();
        cfg = '0;
        surv1 = '0;
        surv2 = '0;
        bio1 = '0;
        bio2 = '0;
        rec1 = '0;
        run_phase = bdds_pkg::PH_FIRST;
        directed_cfg[0] = '{24'h01_0000, 24'h00_1000, 24'h10_0000, 16'h4000, 16'h4000,
                            16'h2000, 32'h0000_6400, 32'h0000_5000};
        directed_cfg[1] = '{24'h0, 24'h0, 24'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF};
        directed_cfg[2] = '{24'h0, 24'h0, 24'h0, 16'hFFFF, 16'h0, 16'hFFFF,
                            32'hFFFF_FFFF, 32'h0};
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        group = -1;
        foreach (steps[i]) begin
            if (steps[i].group != group) begin
                s_tvalid <= 1'b0;
                drain();
                group = steps[i].group;
                load_config(directed_cfg[group]);
                @(negedge aclk);
            end
            send_step(steps[i].run_start, steps[i].et, steps[i].en, steps[i].rec,
                      '{steps[i].typed, steps[i].result});
        end

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s_tvalid <= 1'b0;
            drain();
            load_config(random_cfg(p));
            quiet = (p == 3);
            @(negedge aclk);
            for (int k = 0; k < STEPS_PER_PHASE; k++) begin
                if (k == STEPS_PER_PHASE / 2) begin
                    // hold off until the block has delivered everything
                    s_tvalid <= 1'b0;
                    while (expected_biomass_q.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                if ($urandom_range(0, 3) == 0) begin
                    et = 16'($urandom);
                    en = 16'($urandom);
                end else begin
                    et = 16'($urandom_range(0, 255));
                    en = 16'($urandom_range(0, 255));
                end
                send_step(k == 0 || $urandom_range(0, 39) == 0, et, en,
                          $urandom >> $urandom_range(0, 20), '0);
            end
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("[biomass_delay_difference_step] OK");
        end else begin
            $display("[biomass_delay_difference_step] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("[biomass_delay_difference_step] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/bdds_pkg.sv
sv/bdds_cfg.sv
sv/bdds_ctrl.sv
sv/bdds_dp.sv
sv/biomass_delay_difference_step.sv
sv/bdds_check.sv
test/biomass_delay_difference_step_test.sv
